[design/ascp_pkg.sv]
`timescale 1ns / 1ps

package ascp_pkg;

    localparam int unsigned LaneW     = 64;
    localparam int unsigned NumLanes  = 5;
    localparam int unsigned RcW       = 8;
    localparam logic [3:0]  MaxRounds = 4'd12;

    localparam int unsigned RotA [NumLanes] = '{19, 61, 1, 10, 7};
    localparam int unsigned RotB [NumLanes] = '{28, 39, 6, 17, 41};

    typedef logic [NumLanes-1:0] t_col;
    typedef logic [LaneW-1:0]    t_lane;

    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    function automatic logic [RcW-1:0] round_const(input logic [3:0] r);
        logic [3:0] hi;
        hi = 4'd15 - r;
        return {hi, r};
    endfunction

    function automatic t_lane rotr(input t_lane v, input int unsigned s);
        return (v >> s) | (v << (LaneW - s));
    endfunction

endpackage

[design/ascp_cell.sv]
`timescale 1ns / 1ps

module ascp_cell (
    input  logic                  i_clk,
    input  ascp_pkg::t_cell_ctl   i_ctl,
    input  ascp_pkg::t_col        i_load_col,
    input  ascp_pkg::t_col        i_next_col,
    input  logic                  i_rc,
    output ascp_pkg::t_col        o_col,
    output ascp_pkg::t_col        o_sbox
);

    ascp_pkg::t_col r_col;
    ascp_pkg::t_col n_col;

    always_comb begin
        logic a0, a1, a2, a3, a4;
        logic t0, t1, t2, t3, t4;
        a0 = r_col[0];
        a1 = r_col[1];
        a2 = r_col[2] ^ i_rc;
        a3 = r_col[3];
        a4 = r_col[4];
        a0 = a0 ^ a4;
        a4 = a4 ^ a3;
        a2 = a2 ^ a1;
        t0 = ~a0 & a1;
        t1 = ~a1 & a2;
        t2 = ~a2 & a3;
        t3 = ~a3 & a4;
        t4 = ~a4 & a0;
        a0 = a0 ^ t1;
        a1 = a1 ^ t2;
        a2 = a2 ^ t3;
        a3 = a3 ^ t4;
        a4 = a4 ^ t0;
        a1 = a1 ^ a0;
        a0 = a0 ^ a4;
        a3 = a3 ^ a2;
        a2 = ~a2;
        o_sbox = {a4, a3, a2, a1, a0};
    end

    always_comb begin
        n_col = r_col;
        priority if (i_ctl.load) begin
            n_col = i_load_col;
        end else if (i_ctl.step) begin
            n_col = i_next_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    assign o_col = r_col;

endmodule

[design/ascon_permutation.sv]
`timescale 1ns / 1ps
// Each accepted word runs i_round_count rounds, saturated at 12.
// A new word is taken only while idle, once the last result is in the output register.
// The single round unit is a row of 64 bit-slice cells that performs one round per cycle.
// A finished result waits in the output register while the next word is taken.
// Reset (synchronous, active low) empties the output register and idles the round unit.
module ascon_permutation (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [63:0]         i_lane0_in,
    input  logic [63:0]         i_lane1_in,
    input  logic [63:0]         i_lane2_in,
    input  logic [63:0]         i_lane3_in,
    input  logic [63:0]         i_lane4_in,
    input  logic [3:0]          i_round_count,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [63:0]         o_lane0_out,
    output logic [63:0]         o_lane1_out,
    output logic [63:0]         o_lane2_out,
    output logic [63:0]         o_lane3_out,
    output logic [63:0]         o_lane4_out
);

    localparam int unsigned LaneW    = ascp_pkg::LaneW;
    localparam int unsigned NumLanes = ascp_pkg::NumLanes;
    localparam int unsigned RcW      = ascp_pkg::RcW;

    ascp_pkg::t_state    r_state, n_state;
    logic [3:0]          r_round, n_round;
    logic                r_out_valid, n_out_valid;
    ascp_pkg::t_lane     r_out [NumLanes];
    ascp_pkg::t_lane     n_out [NumLanes];

    ascp_pkg::t_lane     w_in   [NumLanes];
    ascp_pkg::t_lane     w_cur  [NumLanes];
    ascp_pkg::t_lane     w_sbox [NumLanes];
    ascp_pkg::t_lane     w_diff [NumLanes];
    ascp_pkg::t_col      w_col  [LaneW];
    ascp_pkg::t_col      w_sb   [LaneW];
    ascp_pkg::t_cell_ctl w_ctl;
    logic [RcW-1:0]      w_rc;
    logic [3:0]          w_sat;
    logic                w_accept;
    logic                w_done;
    logic                w_out_free;

    assign w_in[0] = i_lane0_in;
    assign w_in[1] = i_lane1_in;
    assign w_in[2] = i_lane2_in;
    assign w_in[3] = i_lane3_in;
    assign w_in[4] = i_lane4_in;

    assign o_ready    = (r_state == ascp_pkg::ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_done     = (r_round == ascp_pkg::MaxRounds);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_sat      = (i_round_count > ascp_pkg::MaxRounds) ? ascp_pkg::MaxRounds
                                                              : i_round_count;
    assign w_rc       = ascp_pkg::round_const(r_round);

    assign w_ctl.load = w_accept;
    assign w_ctl.step = (r_state == ascp_pkg::ST_RUN) && !w_done;

    genvar j, k;
    generate
        for (j = 0; j < LaneW; j++) begin : g_cell
            ascp_pkg::t_col w_ld;
            ascp_pkg::t_col w_nx;
            logic           w_rc_bit;
            for (k = 0; k < NumLanes; k++) begin : g_bit
                assign w_ld[k]       = w_in[k][j];
                assign w_nx[k]       = w_diff[k][j];
                assign w_cur[k][j]   = w_col[j][k];
                assign w_sbox[k][j]  = w_sb[j][k];
            end
            if (j < RcW) begin : g_rc
                assign w_rc_bit = w_rc[j];
            end else begin : g_norc
                assign w_rc_bit = 1'b0;
            end
            ascp_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_load_col (w_ld),
                .i_next_col (w_nx),
                .i_rc       (w_rc_bit),
                .o_col      (w_col[j]),
                .o_sbox     (w_sb[j])
            );
        end
        for (k = 0; k < NumLanes; k++) begin : g_diff
            assign w_diff[k] = w_sbox[k]
                             ^ ascp_pkg::rotr(w_sbox[k], ascp_pkg::RotA[k])
                             ^ ascp_pkg::rotr(w_sbox[k], ascp_pkg::RotB[k]);
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_out_valid = r_out_valid;
        for (int i = 0; i < NumLanes; i++) begin
            n_out[i] = r_out[i];
        end
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ascp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_round = ascp_pkg::MaxRounds - w_sat;
                    n_state = ascp_pkg::ST_RUN;
                end
            end
            ascp_pkg::ST_RUN: begin
                if (!w_done) begin
                    n_round = r_round + 4'd1;
                end else if (w_out_free) begin
                    for (int i = 0; i < NumLanes; i++) begin
                        n_out[i] = w_cur[i];
                    end
                    n_out_valid = 1'b1;
                    n_state     = ascp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ascp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ascp_pkg::ST_IDLE;
            r_round     <= ascp_pkg::MaxRounds;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NumLanes; i++) begin
            r_out[i] <= n_out[i];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_lane0_out = r_out[0];
    assign o_lane1_out = r_out[1];
    assign o_lane2_out = r_out[2];
    assign o_lane3_out = r_out[3];
    assign o_lane4_out = r_out[4];

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= ascp_pkg::MaxRounds)
        else $error("round counter out of range");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ascp_pkg::ST_RUN))
        else $error("accepted word did not start the round unit");

    a_round_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ascp_pkg::ST_RUN) && !w_done) |=>
            ((r_round == $past(r_round) + 4'd1) && (r_state == ascp_pkg::ST_RUN)))
        else $error("round counter did not advance");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ascp_pkg::ST_RUN) && w_done && w_out_free) |=>
            (o_valid && (r_state == ascp_pkg::ST_IDLE)))
        else $error("finished word not moved to output register");

endmodule
